// ===== sv/ttip_pkg.sv =====
// Shared types and constants for the trajectory time interpolator.
`timescale 1ns / 1ps
package ttip_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int TIME_W      = 32;
   localparam int VAL_W       = 16;
   localparam int FRAC_BITS   = 16;
   localparam int QUO_W       = FRAC_BITS + 1;
   localparam int STEP_W      = $clog2(QUO_W);
   localparam int PROD_W      = (VAL_W + 1) + (QUO_W + 1);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FIRST  = 2'd0,
      STATUS_INTERP = 2'd1,
      STATUS_PAST   = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  chan_b;
      logic signed [VAL_W-1:0]  chan_a;
      logic        [TIME_W-1:0] time_stamp;
   } entry_type;

endpackage

// ===== sv/ttip_table.sv =====
// Entry table: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ttip_table
   import ttip_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ttip_divider.sv =====
// Serial restoring divider for the interpolation fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
module ttip_divider
   import ttip_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] rem_ff,  rem_in;
   logic [TIME_W-1:0] den_ff,  den_in;
   logic [QUO_W-1:0]  quo_ff,  quo_in;
   logic [TIME_W:0]   trial;
   logic              fits;

   always_comb begin
      trial = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      fits  = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = dividend;
         den_in  = divisor;
      end else if (run_ff) begin
         rem_in  = fits ? TIME_W'(trial - {1'b0, den_ff}) : trial[TIME_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/trajectory_time_interpolator.sv =====
// Top level: command sequencer, table search and interpolation datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive start with req_* for one cycle; the item transfers at an
//   edge where start is high and busy is low. req_command = 0 writes entry
//   req_entry_index (time, channel a, channel b) and gives no result.
//   req_command = 1 queries req_time_value and gives one result.
//   Result channel: rsp_valid marks each result for exactly one cycle; the
//   receiver cannot stall, so it must take rsp_* in that cycle.
//   csr_write_enable writes csr_write_data into the entry count; write it
//   only while busy is low and no result is pending.
//   Search: a query reads one entry per cycle from the table memory. A hit
//   on the first entry or a miss past the last gives its result straight
//   from the search. An interpolation then runs the serial fraction
//   divider, waits to see it finish, then registers the products and
//   then rounds them into the result.
//   Throughput: one query at a time; busy stays high until its result is out.
//   Reset: clears the sequencer and sets the entry count to 16; table
//   contents stay undefined until written.
module trajectory_time_interpolator
   import ttip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [TIME_W-1:0]       req_time_value,
   input  logic signed [VAL_W-1:0] req_channel_a_value,
   input  logic signed [VAL_W-1:0] req_channel_b_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_channel_a_result,
   output logic signed [VAL_W-1:0] rsp_channel_b_result,
   output logic [1:0]              rsp_lookup_status,
   input  logic                    csr_write_enable,
   input  logic [CNT_W-1:0]        csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIV,
      ST_MUL,
      ST_SUM
   } state_type;

   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         last_ff, last_in;
   logic [TIME_W-1:0]        qtime_ff, qtime_in;
   entry_type                prev_ff, prev_in;
   entry_type                next_ff, next_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_a_ff, rsp_a_in;
   logic signed [VAL_W-1:0]  rsp_b_ff, rsp_b_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic             wr_en;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             div_start;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;
   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] last_full;
   logic signed [VAL_W:0]   diff_a, diff_b;
   logic signed [QUO_W:0]   frac_s;
   logic [PROD_W-1:0]       sum_a, sum_b;

   ttip_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ttip_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (qtime_ff - prev_ff.time_stamp),
      .divisor  (rd_data.time_stamp - prev_ff.time_stamp),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      wr_data = '{chan_b: req_channel_b_value, chan_a: req_channel_a_value,
                  time_stamp: req_time_value};
      priority if (count_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (count_ff > DEPTH_COUNT) begin
         count_eff = DEPTH_COUNT;
      end else begin
         count_eff = count_ff;
      end
      last_full = count_eff - 1'b1;
      diff_a = {next_ff.chan_a[VAL_W-1], next_ff.chan_a}
             - {prev_ff.chan_a[VAL_W-1], prev_ff.chan_a};
      diff_b = {next_ff.chan_b[VAL_W-1], next_ff.chan_b}
             - {prev_ff.chan_b[VAL_W-1], prev_ff.chan_b};
      frac_s = $signed({1'b0, div_quo});
      sum_a  = prod_a_ff + HALF;
      sum_b  = prod_b_ff + HALF;

      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      qtime_in      = qtime_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      rsp_valid_in  = 1'b0;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      div_start     = 1'b0;

      if (csr_write_enable) begin
         count_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  qtime_in = req_time_value;
                  last_in  = last_full[IDX_W-1:0];
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            priority if (rd_data.time_stamp >= qtime_ff) begin
               if (idx_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_a_in      = rd_data.chan_a;
                  rsp_b_in      = rd_data.chan_b;
                  rsp_status_in = STATUS_FIRST;
                  state_in      = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  next_in   = rd_data;
                  state_in  = ST_DIV;
               end
            end else if (idx_ff == last_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_a_in      = rd_data.chan_a;
               rsp_b_in      = rd_data.chan_b;
               rsp_status_in = STATUS_PAST;
               state_in      = ST_IDLE;
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_a_in = PROD_W'(diff_a * frac_s);
            prod_b_in = PROD_W'(diff_b * frac_s);
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            rsp_valid_in  = 1'b1;
            rsp_a_in      = prev_ff.chan_a + $signed(sum_a[FRAC_BITS +: VAL_W]);
            rsp_b_in      = prev_ff.chan_b + $signed(sum_b[FRAC_BITS +: VAL_W]);
            rsp_status_in = STATUS_INTERP;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= DEPTH_COUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      qtime_ff      <= qtime_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                 = state_ff != ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_channel_a_result = rsp_a_ff;
   assign rsp_channel_b_result = rsp_b_ff;
   assign rsp_lookup_status    = rsp_status_ff;

endmodule

// ===== sv/ttip_checker.sv =====
// Port-level checker for the trajectory time interpolator, bound to the top level.
`timescale 1ns / 1ps
module ttip_checker
   import ttip_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_command,
   input logic       rsp_valid,
   input logic [1:0] rsp_lookup_status
);

   a_query_holds_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_QUERY |=> busy)
      else $error("query transfer did not raise busy");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_WRITE |=> !rsp_valid && !busy)
      else $error("write transfer produced a result or busy");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result without a query in flight");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lookup_status == STATUS_FIRST ||
                    rsp_lookup_status == STATUS_INTERP ||
                    rsp_lookup_status == STATUS_PAST)
      else $error("illegal lookup status");

endmodule

bind trajectory_time_interpolator ttip_checker u_ttip_checker (.*);
